[rtl/nand_bad_block_mark_offset_assert.svh]
// Assertion macros for the bad block marker offset block.
// Both expect clk and arst_n in scope.
`ifndef NAND_BAD_BLOCK_MARK_OFFSET_ASSERT_SVH
`define NAND_BAD_BLOCK_MARK_OFFSET_ASSERT_SVH

// Same-cycle implication.
`define NBBM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nbbm assertion failed");

// Next-cycle implication.
`define NBBM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nbbm assertion failed");

`endif

[rtl/nbbm_pkg.sv]
package nbbm_pkg;

	// field widths
	localparam int PAGE_W  = 15;
	localparam int STR_W   = 6;
	localparam int GF_W    = 4;
	localparam int CHUNK_W = 12;
	localparam int META_W  = 8;
	localparam int OFF_W   = 18;
	localparam int STAT_W  = 2;

	// internal widths
	localparam int ECC_W   = STR_W + GF_W;     // strength * order
	localparam int DATA_W  = CHUNK_W + 3;      // chunk bits
	localparam int POS_W   = PAGE_W + 3;       // page bits
	localparam int LEAD_W  = 12;               // meta bits + ecc bits, max 2985
	localparam int TOTAL_W = DATA_W + 1;       // data + ecc bits of one chunk

	// divider: one quotient bit per step
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = POS_W / DIV_STEPS;

	localparam int QUERY_W     = PAGE_W + STR_W + GF_W + 2 * CHUNK_W + META_W;
	localparam int IN_TDATA_W  = ((QUERY_W + 7) / 8) * 8;
	localparam int RESULT_W    = OFF_W + STAT_W;
	localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_IN_ECC  = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	// first member is the high end, so page_bytes sits in the lowest bits
	typedef struct packed {
		logic [META_W-1:0]  meta_bytes;
		logic [CHUNK_W-1:0] chunk_bytes;
		logic [CHUNK_W-1:0] first_chunk_bytes;
		logic [GF_W-1:0]    field_order;
		logic [STR_W-1:0]   bch_strength;
		logic [PAGE_W-1:0]  page_bytes;
	} query_t;

	typedef struct packed {
		status_t            status;
		logic [OFF_W-1:0]   mark_bit_offset;
	} result_t;

	typedef struct packed {
		logic [POS_W-1:0]   pos;
		logic [LEAD_W-1:0]  lead;
		logic [DATA_W-1:0]  data_bits;
		logic [ECC_W-1:0]   ecc_bits;
		logic               bad;
	} s1_t;

	// divider payload: num shifts out dividend bits and takes in quotient bits
	typedef struct packed {
		logic [POS_W-1:0]   pos;
		logic [POS_W-1:0]   num;
		logic [TOTAL_W-1:0] rem;
		logic [TOTAL_W-1:0] divisor;
		logic [DATA_W-1:0]  data_bits;
		logic [ECC_W-1:0]   ecc_bits;
		status_t            status;
	} div_t;

	typedef struct packed {
		logic [POS_W-1:0]   pos;
		logic [POS_W-1:0]   prod;
		status_t            status;
	} fin_t;

endpackage

[rtl/nand_bad_block_mark_offset.sv]
// Bad block marker offset for a BCH NAND page layout. Each s_ transaction
// carries one layout query; each m_ transaction returns its answer, in
// order, one answer per query. The block takes one query per clock while
// s_tready is high. It has setup stages (ECC size, lead-in strip, chunk
// size), the stages of a radix-2 restoring divider retiring two quotient
// bits per stage, and the multiply and final subtract stages, the last one
// being the output register. Every stage holds its own valid bit and only
// stalls when the stage after it is full, so empty slots are squeezed out
// under backpressure and s_tready drops only when every stage holds a
// query. Status 0 gives the offset; status 1 (marker inside ECC bits) and
// status 2 (zero chunk size, oversized page or metadata plus any shared
// ECC larger than the page) force the offset to 0. MAX_PAGE_BYTES sets
// the largest page_bytes accepted as valid.
module nand_bad_block_mark_offset #(
	parameter int MAX_PAGE_BYTES = 16384
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [14:0] page_bytes, [20:15] bch_strength, [24:21] field_order,
	// [36:25] first_chunk_bytes, [48:37] chunk_bytes, [56:49] meta_bytes,
	// [63:57] zero
	input  logic [nbbm_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [17:0] mark_bit_offset, [19:18] status, [23:20] zero
	output logic [nbbm_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	nbbm_pkg::query_t  query;
	nbbm_pkg::div_t    prep_data, div_data;
	nbbm_pkg::result_t result;
	logic              prep_valid, prep_ready;
	logic              div_valid, div_ready;

	// pad bits above the query are ignored
	assign query = nbbm_pkg::query_t'(s_tdata[nbbm_pkg::QUERY_W-1:0]);

	// setup: ECC bits, lead-in removal, divisor, validity checks
	nbbm_prep #(
		.MAX_PAGE_BYTES(MAX_PAGE_BYTES)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_query  (query),
		.out_valid (prep_valid),
		.out_ready (prep_ready),
		.out_data  (prep_data)
	);

	// chunk index and offset within chunk
	nbbm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prep_valid),
		.in_ready  (prep_ready),
		.in_data   (prep_data),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_data  (div_data)
	);

	// remove ECC of earlier chunks, pick status, output register
	nbbm_fin u_fin (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (div_valid),
		.in_ready   (div_ready),
		.in_data    (div_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	assign m_tdata = {(nbbm_pkg::OUT_TDATA_W - nbbm_pkg::RESULT_W)'(0), result};

endmodule

[rtl/nbbm_prep.sv]
module nbbm_prep #(
	parameter int MAX_PAGE_BYTES = 16384
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  nbbm_pkg::query_t    in_query,
	output logic                out_valid,
	input  logic                out_ready,
	output nbbm_pkg::div_t      out_data
);

	localparam int CMP_W = nbbm_pkg::PAGE_W + 2;
	localparam logic [CMP_W-1:0] MaxPage = CMP_W'(MAX_PAGE_BYTES);

	logic             vld_s1, vld_s2;
	logic             rdy_s1, rdy_s2;
	nbbm_pkg::s1_t    dat_s1, nxt_s1;
	nbbm_pkg::div_t   dat_s2, nxt_s2;
	logic [nbbm_pkg::ECC_W-1:0] ecc_c;
	logic             under_c;

	assign rdy_s2   = !vld_s2 || out_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// stage 1: ecc size, scaled sizes, lead-in bits
	always_comb begin
		ecc_c = nbbm_pkg::ECC_W'(nbbm_pkg::ECC_W'(in_query.bch_strength)
			* nbbm_pkg::ECC_W'(in_query.field_order));
		nxt_s1.pos       = {in_query.page_bytes, 3'b000};
		nxt_s1.data_bits = {in_query.chunk_bytes, 3'b000};
		nxt_s1.ecc_bits  = ecc_c;
		nxt_s1.lead      = nbbm_pkg::LEAD_W'({in_query.meta_bytes, 3'b000})
			+ ((in_query.first_chunk_bytes == '0) ? nbbm_pkg::LEAD_W'(ecc_c) : '0);
		nxt_s1.bad       = ({2'b00, in_query.page_bytes} > MaxPage)
			|| (in_query.chunk_bytes == '0);
	end

	// stage 2: strip lead-in, chunk size, seed divider
	always_comb begin
		under_c            = nbbm_pkg::POS_W'(dat_s1.lead) > dat_s1.pos;
		nxt_s2.pos         = dat_s1.pos - nbbm_pkg::POS_W'(dat_s1.lead);
		nxt_s2.num         = nxt_s2.pos;
		nxt_s2.rem         = '0;
		nxt_s2.divisor     = nbbm_pkg::TOTAL_W'(dat_s1.data_bits)
			+ nbbm_pkg::TOTAL_W'(dat_s1.ecc_bits);
		nxt_s2.data_bits   = dat_s1.data_bits;
		nxt_s2.ecc_bits    = dat_s1.ecc_bits;
		nxt_s2.status      = (dat_s1.bad || under_c) ? nbbm_pkg::ST_INVALID
			: nbbm_pkg::ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) dat_s1 <= nxt_s1;
		if (rdy_s2 && vld_s1) dat_s2 <= nxt_s2;
	end

	assign out_valid = vld_s2;
	assign out_data  = dat_s2;

endmodule

[rtl/nbbm_div.sv]
module nbbm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  nbbm_pkg::div_t      in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output nbbm_pkg::div_t      out_data
);

	localparam int NS = nbbm_pkg::DIV_STAGES;

	logic           div_vld_s [NS];
	logic           div_rdy   [NS];
	nbbm_pkg::div_t div_dat_s [NS];
	nbbm_pkg::div_t div_nxt   [NS];

	// one restoring step: shift in a dividend bit, subtract if it fits
	function automatic nbbm_pkg::div_t div_step(input nbbm_pkg::div_t d);
		logic [nbbm_pkg::TOTAL_W:0] t;
		logic [nbbm_pkg::TOTAL_W:0] dv;
		logic                       ge;
		nbbm_pkg::div_t             r;
		r  = d;
		t  = {d.rem, d.num[nbbm_pkg::POS_W-1]};
		dv = {1'b0, d.divisor};
		ge = (t >= dv);
		if (ge) begin
			r.rem = nbbm_pkg::TOTAL_W'(t - dv);
		end else begin
			r.rem = t[nbbm_pkg::TOTAL_W-1:0];
		end
		r.num = {d.num[nbbm_pkg::POS_W-2:0], ge};
		return r;
	endfunction

	always_comb begin
		div_rdy[NS-1] = !div_vld_s[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			div_rdy[k] = !div_vld_s[k] || div_rdy[k+1];
		end
	end

	assign in_ready = div_rdy[0];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		always_comb begin
			div_nxt[g] = (g == 0) ? in_data : div_dat_s[(g == 0) ? 0 : g - 1];
			for (int j = 0; j < nbbm_pkg::DIV_STEPS; j++) begin
				div_nxt[g] = div_step(div_nxt[g]);
			end
		end

		if (g == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					div_vld_s[g] <= 1'b0;
				end else if (div_rdy[g]) begin
					div_vld_s[g] <= in_valid;
				end
			end
			always_ff @(posedge clk) begin
				if (div_rdy[g] && in_valid) div_dat_s[g] <= div_nxt[g];
			end
		end else begin : g_rest
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					div_vld_s[g] <= 1'b0;
				end else if (div_rdy[g]) begin
					div_vld_s[g] <= div_vld_s[g-1];
				end
			end
			always_ff @(posedge clk) begin
				if (div_rdy[g] && div_vld_s[g-1]) div_dat_s[g] <= div_nxt[g];
			end
		end
	end

	assign out_valid = div_vld_s[NS-1];
	assign out_data  = div_dat_s[NS-1];

endmodule

[rtl/nbbm_fin.sv]
module nbbm_fin (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  nbbm_pkg::div_t      in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output nbbm_pkg::result_t   out_result
);

	logic                 vld_s12, vld_s13;
	logic                 rdy_s12, rdy_s13;
	nbbm_pkg::fin_t       dat_s12, nxt_s12;
	nbbm_pkg::result_t    dat_s13, nxt_s13;

	assign rdy_s13  = !vld_s13 || out_ready;
	assign rdy_s12  = !vld_s12 || rdy_s13;
	assign in_ready = rdy_s12;

	// stage 12: ecc bits of earlier chunks, marker-in-ecc check
	always_comb begin
		nxt_s12.pos  = in_data.pos;
		nxt_s12.prod = nbbm_pkg::POS_W'(in_data.num
			* nbbm_pkg::POS_W'(in_data.ecc_bits));
		if (in_data.status == nbbm_pkg::ST_INVALID) begin
			nxt_s12.status = nbbm_pkg::ST_INVALID;
		end else if (in_data.rem > nbbm_pkg::TOTAL_W'(in_data.data_bits)) begin
			nxt_s12.status = nbbm_pkg::ST_IN_ECC;
		end else begin
			nxt_s12.status = nbbm_pkg::ST_OK;
		end
	end

	// stage 13: final offset, zero on any error
	always_comb begin
		nxt_s13.status = dat_s12.status;
		case (dat_s12.status)
			nbbm_pkg::ST_OK: nxt_s13.mark_bit_offset = dat_s12.pos - dat_s12.prod;
			default:         nxt_s13.mark_bit_offset = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else begin
			if (rdy_s12) vld_s12 <= in_valid;
			if (rdy_s13) vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s12 && in_valid) dat_s12 <= nxt_s12;
		if (rdy_s13 && vld_s12) dat_s13 <= nxt_s13;
	end

	assign out_valid  = vld_s13;
	assign out_result = dat_s13;

endmodule

[rtl/nbbm_checker.sv]
`include "nand_bad_block_mark_offset_assert.svh"

module nbbm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [nbbm_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	logic [nbbm_pkg::STAT_W-1:0] st;
	logic [nbbm_pkg::OFF_W-1:0]  off;
	logic                        busy_in;

	assign st      = m_tdata[nbbm_pkg::OFF_W +: nbbm_pkg::STAT_W];
	assign off     = m_tdata[nbbm_pkg::OFF_W-1:0];
	assign busy_in = s_tvalid && !s_tready;

	// error answers carry no offset
	`NBBM_ASSERT_NOW(a_err_zero_off, m_tvalid && (st != nbbm_pkg::ST_OK), off == '0)

	// input stalls only when the pipe is full behind a blocked output
	`NBBM_ASSERT_NOW(a_stall_full, busy_in, m_tvalid && !m_tready)

	// result held while not taken
	`NBBM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`NBBM_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind nand_bad_block_mark_offset nbbm_checker u_nbbm_checker (.*);

[tb/sv/testbench.sv]
// Self-checking bench for nand_bad_block_mark_offset.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PAGE     = 16384;
	localparam int RANDOM_ITEMS = 1200;
	localparam int LONG_STALL   = 300;     // receiver hold-off, cycles
	localparam int DRAIN_CYCLES = 40;      // pipeline is 13 deep
	localparam int CYCLE_LIMIT  = 200000;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	// [14:0] page_bytes, [20:15] bch_strength, [24:21] field_order,
	// [36:25] first_chunk_bytes, [48:37] chunk_bytes, [56:49] meta_bytes
	logic [nbbm_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                             m_tvalid;
	logic                             m_tready;
	// [17:0] mark_bit_offset, [19:18] status
	logic [nbbm_pkg::OUT_TDATA_W-1:0] m_tdata;

	// receiver long hold-off request, raised by the stimulus, cleared by the receiver
	bit long_stall_req;

	nand_bad_block_mark_offset #(
		.MAX_PAGE_BYTES(MAX_PAGE)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// Answer store: every accepted query pushes its predicted answer,
	// every output transaction pops and compares the oldest one.
	class mark_offset_scoreboard;
		nbbm_pkg::result_t expected_answers[$];
		int                errors;

		function new();
			errors = 0;
		endfunction

		// marker position in the data-only view of the raw page
		function nbbm_pkg::result_t predict_mark_offset(nbbm_pkg::query_t q);
			int unsigned       data_bits;
			int unsigned       ecc_bits;
			int unsigned       total_bits;
			int unsigned       pos;
			int unsigned       lead;
			int unsigned       idx;
			int unsigned       chunk_off;
			nbbm_pkg::result_t r;
			data_bits  = 32'(q.chunk_bytes) * 8;
			ecc_bits   = 32'(q.bch_strength) * 32'(q.field_order);
			total_bits = data_bits + ecc_bits;
			pos        = 32'(q.page_bytes) * 8;
			lead       = 32'(q.meta_bytes) * 8;
			r.mark_bit_offset = '0;
			if (q.page_bytes > MAX_PAGE || q.chunk_bytes == 0) begin
				r.status = nbbm_pkg::ST_INVALID;
				return r;
			end
			// chunk zero empty: metadata shares the first chunk's ECC
			if (q.first_chunk_bytes == 0)
				lead += ecc_bits;
			if (lead > pos) begin
				r.status = nbbm_pkg::ST_INVALID;
				return r;
			end
			pos -= lead;
			idx       = pos / total_bits;
			chunk_off = pos - idx * total_bits;
			if (chunk_off > data_bits) begin
				r.status = nbbm_pkg::ST_IN_ECC;
				return r;
			end
			pos -= idx * ecc_bits;
			r.status          = nbbm_pkg::ST_OK;
			r.mark_bit_offset = nbbm_pkg::OFF_W'(pos);
			return r;
		endfunction

		function void note_query(nbbm_pkg::query_t q);
			expected_answers.push_back(predict_mark_offset(q));
		endfunction

		function void check_answer(nbbm_pkg::result_t got);
			nbbm_pkg::result_t exp;
			if (expected_answers.size() == 0) begin
				$error("answer with no query outstanding: status %0d offset %0d",
					got.status, got.mark_bit_offset);
				errors++;
				return;
			end
			exp = expected_answers.pop_front();
			if (got.status !== exp.status) begin
				$error("status: expected %0d, actual %0d", exp.status, got.status);
				errors++;
			end
			if (got.mark_bit_offset !== exp.mark_bit_offset) begin
				$error("mark_bit_offset: expected %0d, actual %0d",
					exp.mark_bit_offset, got.mark_bit_offset);
				errors++;
			end
		endfunction

		function int pending();
			return expected_answers.size();
		endfunction
	endclass

	mark_offset_scoreboard sb = new();

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// reset asserted at time zero, released on a rising edge
	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog: cycle counter ends a hung run.
	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// Monitor: both sides sampled on the same edge as the block sees them.
	// Queries are noted before answers are checked; the output is registered anyway.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_query(nbbm_pkg::query_t'(s_tdata[nbbm_pkg::QUERY_W-1:0]));
			if (m_tvalid && m_tready)
				sb.check_answer(nbbm_pkg::result_t'(m_tdata[nbbm_pkg::RESULT_W-1:0]));
		end
	end

	// Receiver: stretches of one stall pattern each, plus the long
	// hold-off when the stimulus asks for it.
	initial begin : receiver
		int mode;
		int stretch;
		int phase;
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		phase = 0;
		forever begin
			mode    = $urandom_range(0, 3);
			stretch = $urandom_range(8, 64);
			repeat (stretch) begin
				if (long_stall_req) begin
					// hold off long enough for every stage to fill and s_tready to drop
					m_tready <= 1'b0;
					repeat (LONG_STALL) @(posedge clk);
					long_stall_req = 1'b0;
				end
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (phase % 4 != 3);
				endcase
				phase++;
				@(posedge clk);
			end
		end
	end

	// ---------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------
	int burst_left;
	int no_gap_items;   // items to send back to back (fill the pipe)

	// Offer one query and hold it until the transaction completes.
	task automatic send_query(nbbm_pkg::query_t q);
		s_tdata  <= nbbm_pkg::IN_TDATA_W'(q);
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Send with burst pacing: random burst lengths, random gaps between.
	task automatic offer_query(nbbm_pkg::query_t q);
		int gap;
		send_query(q);
		if (no_gap_items > 0) begin
			no_gap_items--;
			return;
		end
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic nbbm_pkg::query_t layout(int page, int strength, int order,
			int first, int chunk, int meta);
		nbbm_pkg::query_t q;
		q.page_bytes        = nbbm_pkg::PAGE_W'(page);
		q.bch_strength      = nbbm_pkg::STR_W'(strength);
		q.field_order       = nbbm_pkg::GF_W'(order);
		q.first_chunk_bytes = nbbm_pkg::CHUNK_W'(first);
		q.chunk_bytes       = nbbm_pkg::CHUNK_W'(chunk);
		q.meta_bytes        = nbbm_pkg::META_W'(meta);
		return q;
	endfunction

	// Mostly plausible layouts; one in ten is raw noise over the full widths.
	function automatic nbbm_pkg::query_t random_query();
		int chunk;
		int page;
		int order;
		int first;
		int meta;
		if ($urandom_range(0, 9) == 0)
			return layout($urandom_range(0, 32767), $urandom_range(0, 63),
				$urandom_range(0, 15), $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(0, 255));
		case ($urandom_range(0, 3))
			0: chunk = 512;
			1: chunk = 1024;
			2: chunk = $urandom_range(1, 4092);
			default: chunk = $urandom_range(1, 64);
		endcase
		case ($urandom_range(0, 2))
			0: begin
				page = chunk * $urandom_range(1, 16);
				if (page > MAX_PAGE)
					page = $urandom_range(0, MAX_PAGE);
			end
			1: page = 512 << $urandom_range(0, 5);
			default: page = $urandom_range(0, MAX_PAGE);
		endcase
		order = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(13, 14);
		case ($urandom_range(0, 3))
			0: first = 0;
			1: first = $urandom_range(0, 4092);
			default: first = chunk;
		endcase
		meta = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 32) : $urandom_range(0, 255);
		return layout(page, $urandom_range(0, 62), order, first, chunk, meta);
	endfunction

	// at least one edge first, so the monitor has noted the last query
	task automatic wait_all_answered();
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	initial begin : stimulus
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		long_stall_req = 1'b0;
		burst_left     = 4;
		no_gap_items   = 0;
		wait (arst_n);
		@(posedge clk);

		// directed corners
		offer_query(layout(2048, 8, 13, 512, 512, 10));      // typical layout
		offer_query(layout(0, 8, 13, 512, 512, 0));          // empty page, marker at 0
		offer_query(layout(0, 8, 13, 512, 512, 1));          // metadata underflow
		offer_query(layout(2048, 8, 13, 512, 0, 10));        // zero chunk size
		offer_query(layout(16384, 62, 14, 4092, 4092, 255)); // largest valid page
		offer_query(layout(16385, 8, 13, 512, 512, 10));     // oversized page
		offer_query(layout(32767, 63, 15, 4095, 4095, 255)); // all ones
		offer_query(layout(0, 0, 0, 0, 0, 0));               // all zeros
		offer_query(layout(4096, 40, 13, 0, 1024, 10));      // metadata shares ECC
		offer_query(layout(100, 62, 14, 0, 512, 0));         // shared ECC alone underflows
		offer_query(layout(100, 62, 14, 1, 512, 0));         // same, no sharing
		offer_query(layout(100, 62, 14, 1, 1, 0));           // marker deep in ECC
		offer_query(layout(512, 8, 13, 512, 512, 0));        // marker exactly at chunk end
		offer_query(layout(53, 1, 13, 0, 16, 0));            // one bit past chunk data
		offer_query(layout(10, 8, 13, 512, 512, 10));        // lead equals page
		offer_query(layout(8192, 0, 13, 512, 512, 16));      // no ECC
		offer_query(layout(8192, 63, 15, 512, 1024, 16));    // odd field order, max product
		offer_query(layout(8192, 24, 1, 4095, 4095, 128));   // odd small order
		offer_query(layout(16384, 62, 14, 0, 1, 255));       // tiny chunks, many divisions
		offer_query(layout(4096, 16, 14, 1024, 1024, 255));  // max metadata

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) begin
				// receiver holds off while the sender keeps offering
				long_stall_req = 1'b1;
				no_gap_items   = 60;
			end
			if (i == 2 * RANDOM_ITEMS / 3) begin
				// sender pause until the pipe has drained
				s_tvalid <= 1'b0;
				wait_all_answered();
			end
			offer_query(random_query());
		end
		s_tvalid <= 1'b0;

		wait_all_answered();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
